FILE: design/wsfe_pkg.sv
// Shared types, constants and byte helpers for the WebSocket frame encoder.
package wsfe_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic CmdHeader  = 1'b0;
  localparam logic CmdPayload = 1'b1;

  localparam logic [6:0]  LenCode16  = 7'd126;
  localparam logic [6:0]  LenCode64  = 7'd127;
  localparam logic [62:0] ShortLimit = 63'd126;
  localparam logic [62:0] Len16Limit = 63'd65536;

  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_16,
    LEN_64
  } len_class_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic          is_payload;
    logic [3:0]    opcode;
    logic          fin;
    logic          masked;
    logic [62:0]   payload_length;
    logic [31:0]   mask_key;
    logic [7:0]    data_byte;
    logic          end_of_payload;
    len_class_t    len_class;
    logic [6:0]    len_code;
    logic          len_zero;
    logic [3:0]    last_step;
  } desc_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = key[7:0];
      2'd1: b = key[15:8];
      2'd2: b = key[23:16];
      2'd3: b = key[31:24];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] len_byte(input logic [62:0] len, input logic [2:0] idx);
    logic [63:0] w;
    w = {1'b0, len};
    return w[8*idx +: 8];
  endfunction

endpackage

FILE: design/wsfe_front.sv
// Front stage: register each request and classify the header length.
module wsfe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             command,
  input  logic [3:0]       opcode,
  input  logic             fin,
  input  logic             masked,
  input  logic [62:0]      payload_length,
  input  logic [31:0]      mask_key,
  input  logic [7:0]       data_byte,
  input  logic             end_of_payload,
  output logic             desc_valid,
  output wsfe_pkg::desc_t  desc,
  input  logic             desc_ready
);
  import wsfe_pkg::*;

  logic  valid;
  logic  accept;
  desc_t desc_next;

  assign full       = valid && !desc_ready;
  assign accept     = push && !full;
  assign desc_valid = valid;

  always_comb begin
    logic [3:0] n_ext;
    desc_next                = '0;
    desc_next.is_payload     = (command == CmdPayload);
    desc_next.opcode         = opcode;
    desc_next.fin            = fin;
    desc_next.masked         = masked;
    desc_next.payload_length = payload_length;
    desc_next.mask_key       = mask_key;
    desc_next.data_byte      = data_byte;
    desc_next.end_of_payload = end_of_payload;
    desc_next.len_zero       = (payload_length == '0);
    priority if (payload_length < ShortLimit) begin
      desc_next.len_class = LEN_SHORT;
      desc_next.len_code  = payload_length[6:0];
      n_ext               = 4'd0;
    end else if (payload_length < Len16Limit) begin
      desc_next.len_class = LEN_16;
      desc_next.len_code  = LenCode16;
      n_ext               = Ext16Bytes;
    end else begin
      desc_next.len_class = LEN_64;
      desc_next.len_code  = LenCode64;
      n_ext               = Ext64Bytes;
    end
    // Header runs from step 0 to 1 + extension + key bytes.
    if (command == CmdPayload) begin
      desc_next.last_step = 4'd0;
    end else begin
      desc_next.last_step = 4'd1 + n_ext + (masked ? KeyBytes : 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (desc_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc <= desc_next;
    end
  end

endmodule

FILE: design/wsfe_queue.sv
// Short request queue between the front and back stages.
module wsfe_queue #(
  parameter int unsigned Depth = wsfe_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wsfe_pkg::desc_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wsfe_pkg::desc_t  out_data
);
  import wsfe_pkg::*;

  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]   LastPtr = PtrW'(Depth - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(Depth);

  desc_t             store [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign in_ready  = (count != FullCount);
  assign out_valid = (count != '0);
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;
  assign out_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CountW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= in_data;
    end
  end

endmodule

FILE: design/wsfe_back.sv
// Back stage: serialise each request into bytes and hold the masking state.
module wsfe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             desc_valid,
  input  wsfe_pkg::desc_t  desc,
  output logic             desc_ready,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             frame_done
);
  import wsfe_pkg::*;

  logic       out_valid;
  logic       advance;
  logic       emit;
  logic       is_last;
  logic [3:0] step;
  logic       mask_enabled;
  logic [31:0] key_reg;
  logic [1:0] key_index;
  logic [7:0] byte_next;

  assign empty      = !out_valid;
  assign advance    = !out_valid || pop;
  assign emit       = desc_valid && advance;
  assign is_last    = desc.is_payload || (step == desc.last_step);
  assign desc_ready = emit && is_last;

  always_comb begin
    logic [3:0] n_ext;
    logic [3:0] ext_pos;
    logic [3:0] key_pos;
    logic [3:0] len_idx;
    unique case (desc.len_class)
      LEN_16:  n_ext = Ext16Bytes;
      LEN_64:  n_ext = Ext64Bytes;
      default: n_ext = 4'd0;
    endcase
    ext_pos = step - 4'd2;
    key_pos = step - 4'd2 - n_ext;
    len_idx = n_ext - 4'd1 - ext_pos;
    if (desc.is_payload) begin
      byte_next = desc.data_byte ^ (mask_enabled ? key_byte(key_reg, key_index) : 8'h00);
    end else if (step == 4'd0) begin
      byte_next = {desc.fin, 3'b000, desc.opcode};
    end else if (step == 4'd1) begin
      byte_next = {desc.masked, desc.len_code};
    end else if (step < 4'd2 + n_ext) begin
      // Extended length, most significant byte first.
      byte_next = len_byte(desc.payload_length, len_idx[2:0]);
    end else begin
      byte_next = key_byte(desc.mask_key, key_pos[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      step         <= '0;
      mask_enabled <= 1'b0;
      key_reg      <= '0;
      key_index    <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        step <= is_last ? 4'd0 : step + 4'd1;
        if (!desc.is_payload && is_last) begin
          mask_enabled <= desc.masked;
          key_reg      <= desc.mask_key;
          key_index    <= '0;
        end else if (desc.is_payload && mask_enabled) begin
          key_index <= key_index + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= byte_next;
      last_of_run <= is_last;
      frame_done  <= desc.is_payload ? desc.end_of_payload : (is_last && desc.len_zero);
    end
  end

endmodule

FILE: design/websocket_frame_encoder_top.sv
// Top level of the WebSocket frame encoder: front, request queue and back stage.
// Path: a request's first byte passes the front register, queue and back output register.
// Output: a payload request yields one byte; a header yields 2 to 14 bytes, set by the
// back stage's sequencer, emitting one byte a cycle while the output is empty or popped.
// Reset: synchronous, active high; clears the queue, the sequencer and the masking state.
module websocket_frame_encoder_top #(
  parameter int unsigned QueueDepth = wsfe_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [3:0]  opcode,
  input  logic        fin,
  input  logic        masked,
  input  logic [62:0] payload_length,
  input  logic [31:0] mask_key,
  input  logic [7:0]  data_byte,
  input  logic        end_of_payload,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        frame_done
);
  import wsfe_pkg::*;

  // Front to queue: one classified request, held until the queue has room.
  logic  front_valid;
  logic  front_ready;
  desc_t front_desc;

  // Queue to back: oldest request waiting to be serialised.
  logic  back_valid;
  logic  back_ready;
  desc_t back_desc;

  // Accept a request and work out the length code and header size.
  wsfe_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .opcode         (opcode),
    .fin            (fin),
    .masked         (masked),
    .payload_length (payload_length),
    .mask_key       (mask_key),
    .data_byte      (data_byte),
    .end_of_payload (end_of_payload),
    .desc_valid     (front_valid),
    .desc           (front_desc),
    .desc_ready     (front_ready)
  );

  // Decouple the two sides so a long header does not stall the input at once.
  wsfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_desc),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_data  (back_desc)
  );

  // One byte per cycle into the output register, pop permitting; masking state lives here.
  wsfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .desc_valid  (back_valid),
    .desc        (back_desc),
    .desc_ready  (back_ready),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

endmodule
